// ===== rtl/core/fmn_pkg.sv =====
package fmn_pkg;

    // Width of the rate words and of the divider's divisor and remainder
    localparam int DW = 32;

    typedef struct packed {
        logic busy;
        logic done;
    } fmn_div_stat_t;

endpackage

// ===== rtl/core/fractional_divider_mn_search_unit.sv =====
// Channel   | Handshake          | Payload
// ----------+--------------------+------------------------------------------
// request   | in_valid/in_ready  | mode, parent_freq, target_rate
// result    | out_valid/out_ready| status, mult_m, div_n, actual_rate
//
// The sequencer checks, divides parent by target, divides parent * M_LIMIT (PW = 32 +
// bits of M_LIMIT wide) by target, searches M at one candidate per cycle and divides
// parent * M by N; errors and exact fits skip steps. The divides share one bit-serial divider.
// in_ready is high only while the sequencer is idle. Reset is asynchronous, active low.
// A result waits in the output register while the next request runs; a second result
// holds in the last state until out_ready frees the register.
module fractional_divider_mn_search_unit
    import fmn_pkg::*;
#(
    parameter int M_LIMIT = 511,
    parameter int N_LIMIT = 1048575
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             mode,
    input  logic [DW - 1:0]                  parent_freq,
    input  logic [DW - 1:0]                  target_rate,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [1:0]                       status,
    output logic [$clog2(M_LIMIT + 1) - 1:0] mult_m,
    output logic [$clog2(N_LIMIT + 1) - 1:0] div_n,
    output logic [DW - 1:0]                  actual_rate
);

    localparam int MW = $clog2(M_LIMIT + 1);
    localparam int NW = $clog2(N_LIMIT + 1);
    localparam int PW = DW + MW;
    localparam int CW = $clog2(PW + 1);

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_PARENT_LOW  = 2'd1;
    localparam logic [1:0] ST_NO_PAIR     = 2'd2;
    localparam logic [1:0] ST_ZERO_TARGET = 2'd3;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_CHECK   = 3'd1;
    localparam logic [2:0] S_DIV1    = 3'd2;
    localparam logic [2:0] S_DIV2    = 3'd3;
    localparam logic [2:0] S_SEARCH  = 3'd4;
    localparam logic [2:0] S_RATE_GO = 3'd5;
    localparam logic [2:0] S_RATE    = 3'd6;
    localparam logic [2:0] S_DONE    = 3'd7;

    logic [2:0]      state_reg;
    logic [2:0]      state_next;

    logic            mode_reg;
    logic [DW - 1:0] parent_reg;
    logic [DW - 1:0] target_reg;
    logic [DW - 1:0] q_reg;
    logic [DW - 1:0] r_reg;
    logic [MW - 1:0] m_reg;
    logic [PW - 1:0] n_reg;
    logic [DW - 1:0] rem_reg;
    logic [DW - 1:0] best_rem_reg;
    logic [MW - 1:0] best_m_reg;
    logic [NW - 1:0] best_n_reg;
    logic            found_reg;
    logic [1:0]      res_status_reg;
    logic [DW - 1:0] rate_reg;

    logic            out_valid_reg;
    logic [1:0]      status_reg;
    logic [MW - 1:0] mult_m_reg;
    logic [NW - 1:0] div_n_reg;
    logic [DW - 1:0] actual_rate_reg;

    // divider hookup
    fmn_div_stat_t   div_stat;
    logic            div_start;
    logic [CW - 1:0] div_iters;
    logic [PW - 1:0] div_dividend;
    logic [DW - 1:0] div_divisor;
    logic [PW - 1:0] div_quot;
    logic [DW - 1:0] div_rem;

    logic [MW - 1:0] mul_sel;
    logic [PW - 1:0] mul_prod;

    logic            in_acc;
    logic            out_load;
    logic            zero_tgt;
    logic            parent_low;
    logic [DW - 1:0] q_now;
    logic            exact;
    logic            q_over;
    logic            cand_ok;
    logic            cand_exact;
    logic            cand_take;
    logic            last_m;
    logic [DW:0]     rem_diff;
    logic            borrow;
    logic [DW - 1:0] rem_step;
    logic [PW - 1:0] n_step;

    fmn_div #(
        .PW (PW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .iters     (div_iters),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .stat      (div_stat),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    always_comb
    begin
        in_acc     = in_valid && in_ready;
        out_load   = (state_reg == S_DONE) && (!out_valid_reg || out_ready);
        zero_tgt   = (target_reg == '0);
        parent_low = mode_reg && ({1'b0, parent_reg} < {target_reg, 1'b0});
        q_now      = div_quot[DW - 1:0];
        exact      = (div_rem == '0) && (q_now > DW'(1));
        q_over     = (q_now > DW'(N_LIMIT));

        // candidate must satisfy 2M <= N <= N_LIMIT
        cand_ok    = (n_reg >= PW'({m_reg, 1'b0})) && (n_reg <= PW'(N_LIMIT));
        cand_exact = cand_ok && (rem_reg == '0);
        cand_take  = cand_ok && (rem_reg < best_rem_reg);
        last_m     = (m_reg == MW'(1));

        // step to M-1: subtract parent = q*target + r from the product
        rem_diff   = {1'b0, rem_reg} - {1'b0, r_reg};
        borrow     = rem_diff[DW];
        rem_step   = borrow ? (rem_diff[DW - 1:0] + target_reg) : rem_diff[DW - 1:0];
        n_step     = n_reg - PW'(q_reg) - PW'(borrow);

        mul_sel    = (state_reg == S_RATE_GO) ? best_m_reg : MW'(M_LIMIT);
        mul_prod   = PW'(parent_reg) * PW'(mul_sel);
    end

    always_comb
    begin
        div_start    = 1'b0;
        div_iters    = CW'(PW);
        div_dividend = mul_prod;
        div_divisor  = target_reg;
        unique case (state_reg)
            S_CHECK:
            begin
                div_start    = !zero_tgt && !parent_low;
                div_iters    = CW'(DW);
                div_dividend = {parent_reg, MW'(0)};
            end
            S_DIV1:
            begin
                div_start = div_stat.done && !exact;
            end
            S_RATE_GO:
            begin
                div_start   = 1'b1;
                div_divisor = DW'(best_n_reg);
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (zero_tgt || parent_low)
                    state_next = S_DONE;
                else
                    state_next = S_DIV1;
            end
            S_DIV1:
            begin
                if (div_stat.done)
                begin
                    if (!exact)
                        state_next = S_DIV2;
                    else if (q_over)
                        state_next = S_DONE;
                    else
                        state_next = S_RATE_GO;
                end
            end
            S_DIV2:
            begin
                if (div_stat.done)
                    state_next = S_SEARCH;
            end
            S_SEARCH:
            begin
                if (cand_exact)
                    state_next = S_RATE_GO;
                else if (last_m)
                    state_next = (found_reg || cand_take) ? S_RATE_GO : S_DONE;
            end
            S_RATE_GO:
            begin
                state_next = S_RATE;
            end
            S_RATE:
            begin
                if (div_stat.done)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (state_reg == S_DIV2)
                found_reg <= 1'b0;
            else if (state_reg == S_SEARCH && cand_take)
                found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            mode_reg   <= mode;
            parent_reg <= parent_freq;
            target_reg <= target_rate;
        end

        case (state_reg)
            S_CHECK:
            begin
                if (zero_tgt)
                    res_status_reg <= ST_ZERO_TARGET;
                else if (parent_low)
                    res_status_reg <= ST_PARENT_LOW;
            end
            S_DIV1:
            begin
                if (div_stat.done)
                begin
                    q_reg <= q_now;
                    r_reg <= div_rem;
                    if (exact)
                    begin
                        best_m_reg     <= MW'(1);
                        best_n_reg     <= NW'(q_now);
                        res_status_reg <= q_over ? ST_NO_PAIR : ST_OK;
                    end
                end
            end
            S_DIV2:
            begin
                if (div_stat.done)
                begin
                    m_reg        <= MW'(M_LIMIT);
                    n_reg        <= div_quot;
                    rem_reg      <= div_rem;
                    best_rem_reg <= target_reg;
                end
            end
            S_SEARCH:
            begin
                if (cand_exact || cand_take)
                begin
                    best_m_reg   <= m_reg;
                    best_n_reg   <= NW'(n_reg);
                    best_rem_reg <= rem_reg;
                end
                if (cand_exact || (last_m && (found_reg || cand_take)))
                    res_status_reg <= ST_OK;
                else if (last_m)
                    res_status_reg <= ST_NO_PAIR;
                else
                begin
                    m_reg   <= m_reg - MW'(1);
                    n_reg   <= n_step;
                    rem_reg <= rem_step;
                end
            end
            S_RATE:
            begin
                if (div_stat.done)
                    rate_reg <= div_quot[DW - 1:0];
            end
            default:
            begin
            end
        endcase

        if (out_load)
        begin
            status_reg <= res_status_reg;
            if (res_status_reg == ST_OK)
            begin
                mult_m_reg      <= best_m_reg;
                div_n_reg       <= best_n_reg;
                actual_rate_reg <= rate_reg;
            end
            else
            begin
                mult_m_reg      <= '0;
                div_n_reg       <= '0;
                actual_rate_reg <= '0;
            end
        end
    end

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign mult_m      = mult_m_reg;
    assign div_n       = div_n_reg;
    assign actual_rate = actual_rate_reg;

`ifndef SYNTH
    a_ok_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_OK) |->
            (mult_m != '0) && (PW'(div_n) >= PW'({mult_m, 1'b0})))
        else $error("ok result with out-of-range pair");
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_OK) |->
            (mult_m == '0) && (div_n == '0) && (actual_rate == '0))
        else $error("error result with nonzero fields");
    a_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !div_stat.busy)
        else $error("request taken while divider busy");
`endif

endmodule

// ===== rtl/core/fmn_div.sv =====
// Shared restoring divider, one quotient bit per cycle
module fmn_div
    import fmn_pkg::*;
#(
    parameter int PW = 41
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [$clog2(PW + 1) - 1:0]  iters,
    input  logic [PW - 1:0]              dividend,
    input  logic [DW - 1:0]              divisor,
    output fmn_div_stat_t                stat,
    output logic [PW - 1:0]              quotient,
    output logic [DW - 1:0]              remainder
);

    localparam int CW = $clog2(PW + 1);

    logic [PW - 1:0] dq_reg;
    logic [DW - 1:0] rem_reg;
    logic [DW - 1:0] div_reg;
    logic [CW - 1:0] cnt_reg;
    logic            busy_reg;
    logic            done_reg;

    logic [DW:0]     trial;
    logic [DW:0]     trial_sub;
    logic            ge;

    always_comb
    begin
        trial     = {rem_reg, dq_reg[PW - 1]};
        trial_sub = trial - {1'b0, div_reg};
        ge        = (trial >= {1'b0, div_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= iters;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dq_reg  <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            // shift in the next dividend bit, subtract when it fits
            dq_reg  <= {dq_reg[PW - 2:0], ge};
            rem_reg <= ge ? trial_sub[DW - 1:0] : trial[DW - 1:0];
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = dq_reg;
    assign remainder = rem_reg;

`ifndef SYNTH
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg)
        else $error("divider not busy after start");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider done while still busy");
    a_busy_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> cnt_reg != '0)
        else $error("divider busy with zero count");
`endif

endmodule

// ===== test/tb_fractional_divider_mn_search_unit.sv =====
`timescale 1ns / 1ps

module tb_fractional_divider_mn_search_unit;
    import fmn_pkg::*;

    localparam int M_MAX = 511;
    localparam int N_MAX = 1048575;
    localparam int IDLE_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 700;
    localparam int RANDOM_REQUESTS = 1000;

    localparam logic MODE_ROUND = 1'b0;
    localparam logic MODE_SET = 1'b1;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_PARENT_LOW = 2'd1;
    localparam logic [1:0] ST_NO_PAIR = 2'd2;
    localparam logic [1:0] ST_ZERO_TARGET = 2'd3;

    typedef struct {
        logic            req_mode;
        logic [DW - 1:0] req_parent;
        logic [DW - 1:0] req_target;
        logic [1:0]      status;
        logic [8:0]      mult_m;
        logic [19:0]     div_n;
        logic [DW - 1:0] rate;
    } mn_choice_t;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            in_valid = 1'b0;
    logic            in_ready;
    logic            mode = 1'b0;
    logic [DW - 1:0] parent_freq = '0;
    logic [DW - 1:0] target_rate = '0;
    logic            out_valid;
    logic            out_ready = 1'b0;
    logic [1:0]      status;
    logic [8:0]      mult_m;
    logic [19:0]     div_n;
    logic [DW - 1:0] actual_rate;

    mn_choice_t pending_choices[$];
    int         mismatches = 0;
    int         n_requests = 0;
    int         n_results = 0;
    int         status_seen[4] = '{0, 0, 0, 0};
    int         burst_left = 0;
    int         hold_off_left = 0;
    int         idle_cycles = 0;
    logic [15:0] ready_pattern = 16'hFFFF;
    logic [7:0]  ready_phase = 8'd0;

    fractional_divider_mn_search_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .parent_freq (parent_freq),
        .target_rate (target_rate),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .mult_m      (mult_m),
        .div_n       (div_n),
        .actual_rate (actual_rate)
    );

    always #5 clk = ~clk;

    function automatic mn_choice_t predict_mn_choice(input logic md, input logic [DW - 1:0] p,
                                                     input logic [DW - 1:0] t);
        mn_choice_t      c;
        longint unsigned parent;
        longint unsigned target;
        longint unsigned prod;
        longint unsigned n;
        longint unsigned rem;
        longint unsigned best_rem;
        longint unsigned best_n;
        longint unsigned best_m;
        bit              found;
        c.req_mode = md;
        c.req_parent = p;
        c.req_target = t;
        c.status = ST_OK;
        c.mult_m = '0;
        c.div_n = '0;
        c.rate = '0;
        parent = p;
        target = t;
        found = 1'b0;
        best_m = 0;
        best_n = 0;
        if (target == 0) begin
            c.status = ST_ZERO_TARGET;
            return c;
        end
        if (md == MODE_SET && parent < 2 * target) begin
            c.status = ST_PARENT_LOW;
            return c;
        end
        if (parent % target == 0 && parent / target > 1) begin
            if (parent / target > N_MAX) begin
                c.status = ST_NO_PAIR;
                return c;
            end
            best_m = 1;
            best_n = parent / target;
            found = 1'b1;
        end
        else begin
            best_rem = target;
            // scan M downward; strict compare keeps the larger M on a tie
            for (int m = M_MAX; m >= 1; m--) begin
                prod = parent * m;
                n = prod / target;
                rem = prod % target;
                if (n < 2 * m || n > N_MAX)
                    continue;
                if (rem == 0) begin
                    best_m = m;
                    best_n = n;
                    found = 1'b1;
                    break;
                end
                if (rem < best_rem) begin
                    best_m = m;
                    best_n = n;
                    best_rem = rem;
                    found = 1'b1;
                end
            end
        end
        if (!found || best_n == 0) begin
            c.status = ST_NO_PAIR;
            return c;
        end
        c.mult_m = 9'(best_m);
        c.div_n = 20'(best_n);
        c.rate = DW'((parent * best_m) / best_n);
        return c;
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatches < 100)
            $display("MISMATCH at %0t: %s", $time, what);
        mismatches++;
    endtask

    task automatic check_result();
        mn_choice_t exp;
        string      req;
        if (pending_choices.size() == 0) begin
            report_mismatch("result with no request pending");
            return;
        end
        exp = pending_choices.pop_front();
        n_results++;
        status_seen[status]++;
        req = $sformatf("mode %0d parent %0d target %0d", exp.req_mode, exp.req_parent,
                        exp.req_target);
        if (status !== exp.status)
            report_mismatch($sformatf("%s: status %0d, expected %0d", req, status, exp.status));
        if (mult_m !== exp.mult_m)
            report_mismatch($sformatf("%s: mult_m %0d, expected %0d", req, mult_m, exp.mult_m));
        if (div_n !== exp.div_n)
            report_mismatch($sformatf("%s: div_n %0d, expected %0d", req, div_n, exp.div_n));
        if (actual_rate !== exp.rate)
            report_mismatch($sformatf("%s: actual_rate %0d, expected %0d", req, actual_rate,
                                      exp.rate));
    endtask

    // result side: check, then pick the next ready value
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready)
            check_result();
        if (hold_off_left > 0) begin
            hold_off_left--;
            out_ready <= 1'b0;
        end
        else begin
            if (ready_phase == 8'd0) begin
                case ($urandom_range(0, 3))
                    0: ready_pattern = 16'hFFFF;
                    1: ready_pattern = 16'($urandom);
                    2: ready_pattern = 16'($urandom | $urandom);
                    default: ready_pattern = 16'h0001 << $urandom_range(0, 15);
                endcase
            end
            out_ready <= ready_pattern[ready_phase[3:0]];
            ready_phase <= ready_phase + 8'd1;
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no request or result moved for %0d cycles", IDLE_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_request(input logic md, input logic [DW - 1:0] p,
                                input logic [DW - 1:0] t);
        in_valid <= 1'b1;
        mode <= md;
        parent_freq <= p;
        target_rate <= t;
        do
            @(posedge clk);
        while (!in_ready);
        pending_choices.push_back(predict_mn_choice(md, p, t));
        n_requests++;
        if (burst_left > 0) begin
            burst_left--;
        end
        else begin
            in_valid <= 1'b0;
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 700)) @(posedge clk);
            else
                repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = $urandom_range(0, 11);
        end
    endtask

    // drop valid and hold until every pending result is back
    task automatic drain_results();
        if (in_valid)
            in_valid <= 1'b0;
        burst_left = 0;
        while (pending_choices.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic test_directed_cases();
        send_request(MODE_ROUND, 32'd100, 32'd0);
        send_request(MODE_SET, 32'hFFFF_FFFF, 32'd0);
        send_request(MODE_SET, 32'd0, 32'd0);
        send_request(MODE_SET, 32'd199, 32'd100);
        send_request(MODE_SET, 32'd200, 32'd100);
        send_request(MODE_SET, 32'd201, 32'd100);
        send_request(MODE_ROUND, 32'd150, 32'd100);
        send_request(MODE_ROUND, 32'd0, 32'd5);
        send_request(MODE_ROUND, 32'd1000, 32'd1000);
        send_request(MODE_ROUND, 32'd1048575, 32'd1);
        send_request(MODE_ROUND, 32'd1048576, 32'd1);
        send_request(MODE_SET, 32'hFFFF_FFFF, 32'd1);
        send_request(MODE_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(MODE_ROUND, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(MODE_ROUND, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        send_request(MODE_ROUND, 32'd1, 32'hFFFF_FFFF);
        send_request(MODE_SET, 32'd5, 32'd2);
        send_request(MODE_SET, 32'd100_000_000, 32'd12_288_000);
        send_request(MODE_SET, 32'd24_000_000, 32'd11_289_600);
        send_request(MODE_ROUND, 32'hFFFF_FFFF, 32'd7);
        send_request(MODE_ROUND, 32'd2_000_000_000, 32'd4000);
        send_request(MODE_SET, 32'd1_000_000_007, 32'd3);
        send_request(MODE_ROUND, 32'd48_000_000, 32'd9600);
        drain_results();
    endtask

    task automatic test_output_backpressure();
        hold_off_left = 3000;
        burst_left = 6;
        repeat (6)
            send_request(1'($urandom_range(0, 1)), $urandom_range(32'hFFFF_FFFF, 1_000_000),
                         $urandom_range(5_000_000, 1000));
        drain_results();
    endtask

    task automatic test_random_requests(input int count);
        logic            md;
        logic [DW - 1:0] p;
        logic [DW - 1:0] t;
        longint unsigned lim;
        int unsigned     cls;
        int unsigned     m0;
        int unsigned     n0;
        int unsigned     k;
        for (int i = 0; i < count; i++) begin
            md = 1'($urandom_range(0, 1));
            cls = $urandom_range(0, 19);
            if (cls < 6) begin
                // rates a clock driver would ask for
                p = $urandom_range(32'hFFFF_FFFF, 1_000_000);
                t = p / $urandom_range(5000, 2) + $urandom_range(999, 0);
            end
            else if (cls < 9) begin
                // parent an exact multiple of target, quotient may pass the N range
                t = $urandom_range(1, 1 << 20);
                lim = 64'hFFFF_FFFF / t;
                if (lim > 2_000_000)
                    lim = 2_000_000;
                p = t * $urandom_range(0, 32'(lim));
            end
            else if (cls < 12) begin
                // plant an exact fit somewhere in the M scan
                m0 = $urandom_range(1, M_MAX);
                n0 = $urandom_range(2 * m0, N_MAX);
                lim = 64'hFFFF_FFFF / n0;
                if (lim > 4000)
                    lim = 4000;
                k = $urandom_range(1, 32'(lim));
                p = k * n0;
                t = k * m0;
            end
            else if (cls < 16) begin
                p = $urandom;
                t = $urandom >> $urandom_range(0, 31);
            end
            else if (cls < 17) begin
                p = $urandom;
                t = '0;
            end
            else begin
                // parent around twice the target
                t = $urandom_range(1, 32'h7FFF_FFFF);
                p = 2 * t + $urandom_range(0, 2) - 1;
            end
            send_request(md, p, t);
        end
        drain_results();
    endtask

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_output_backpressure();
        test_random_requests(RANDOM_REQUESTS);
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("covered %0d divider requests, %0d results checked", n_requests, n_results);
        $display("status mix: ok %0d, parent low %0d, no pair %0d, zero target %0d",
                 status_seen[ST_OK], status_seen[ST_PARENT_LOW], status_seen[ST_NO_PAIR],
                 status_seen[ST_ZERO_TARGET]);
        if (mismatches == 0 && pending_choices.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
